[design/bte_pkg.sv]
// Package for the Bezier triangle evaluator: shared types, codes and the
// microprogram that sequences the shared multiplier and divider.
// Used by the top level, the checker and the testbench; depends on nothing.
package bte_pkg;

	localparam int PT_BITS    = 24;
	localparam int WORD_BITS  = 32;
	localparam int OUT_BITS   = 48;
	localparam int AREA_BITS  = 68;
	localparam int ORD_SLOTS  = 10;
	localparam int PROG_LEN   = 83;
	localparam int PC_BITS    = $clog2(PROG_LEN);

	// Table slot codes.
	localparam logic [3:0] SLOT_AX = 4'd0;
	localparam logic [3:0] SLOT_AY = 4'd1;
	localparam logic [3:0] SLOT_BX = 4'd2;
	localparam logic [3:0] SLOT_BY = 4'd3;
	localparam logic [3:0] SLOT_CX = 4'd4;
	localparam logic [3:0] SLOT_CY = 4'd5;
	localparam logic [3:0] SLOT_HA = 4'd6;

	// Operand indexes: corner and point coordinates, weights, areas, outputs.
	localparam logic [2:0] CI_AX = 3'd0;
	localparam logic [2:0] CI_AY = 3'd1;
	localparam logic [2:0] CI_BX = 3'd2;
	localparam logic [2:0] CI_BY = 3'd3;
	localparam logic [2:0] CI_CX = 3'd4;
	localparam logic [2:0] CI_CY = 3'd5;
	localparam logic [2:0] CI_PX = 3'd6;
	localparam logic [2:0] CI_PY = 3'd7;
	localparam logic [2:0] W_P   = 3'd0;
	localparam logic [2:0] W_Q   = 3'd1;
	localparam logic [2:0] W_R   = 3'd2;
	localparam logic [1:0] AI_D  = 2'd0;
	localparam logic [1:0] AI_P  = 2'd1;
	localparam logic [1:0] AI_Q  = 2'd2;
	localparam logic [1:0] AI_R  = 2'd3;
	localparam logic [1:0] OI_ELEV = 2'd0;
	localparam logic [1:0] OI_SP   = 2'd1;
	localparam logic [1:0] OI_SQ   = 2'd2;
	localparam logic [1:0] OI_SR   = 2'd3;

	typedef enum logic [2:0] {OP_MUL, OP_CHECK, OP_DIV, OP_ROUND, OP_DONE} op_kind_t;
	typedef enum logic [1:0] {SRC_DIFF, SRC_WGT, SRC_MREG, SRC_WORD} src_t;
	typedef enum logic [1:0] {COEF_1, COEF_3, COEF_6} coef_t;
	typedef enum logic [1:0] {DST_AREA_SET, DST_AREA_SUB, DST_MREG, DST_ACC} dest_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_LOAD, S_MUL, S_FIN1, S_FIN2,
		S_DIV0, S_DIV1, S_DIVS, S_DIVF, S_REPLY
	} state_t;

	// One microinstruction of the evaluation program.
	typedef struct packed {
		op_kind_t   kind;
		src_t       asel;
		logic [2:0] ai;
		logic [2:0] aj;
		src_t       bsel;
		logic [2:0] bi;
		logic [2:0] bj;
		logic       sh28;
		coef_t      coef;
		logic [3:0] slot;
		dest_t      dest;
		logic [1:0] idx;
	} uop_t;

	function automatic uop_t u_ctl(op_kind_t k, logic [1:0] i);
		uop_t u;
		u = '0;
		u.kind = k;
		u.idx = i;
		return u;
	endfunction

	// Product of two coordinate differences, (v1-u1)*(w1-w2), into an area.
	function automatic uop_t u_area(dest_t d, logic [1:0] i, logic [2:0] v1,
			logic [2:0] u1, logic [2:0] w1, logic [2:0] w2);
		uop_t u;
		u = '0;
		u.kind = OP_MUL;
		u.asel = SRC_DIFF;
		u.ai = v1;
		u.aj = u1;
		u.bsel = SRC_DIFF;
		u.bi = w1;
		u.bj = w2;
		u.dest = d;
		u.idx = i;
		return u;
	endfunction

	function automatic uop_t u_ww(logic [2:0] i, logic [2:0] j);
		uop_t u;
		u = '0;
		u.kind = OP_MUL;
		u.asel = SRC_WGT;
		u.ai = i;
		u.bsel = SRC_WGT;
		u.bi = j;
		u.sh28 = 1'b1;
		u.dest = DST_MREG;
		return u;
	endfunction

	function automatic uop_t u_mw(logic [2:0] j);
		uop_t u;
		u = '0;
		u.kind = OP_MUL;
		u.asel = SRC_MREG;
		u.bsel = SRC_WGT;
		u.bi = j;
		u.sh28 = 1'b1;
		u.dest = DST_MREG;
		return u;
	endfunction

	function automatic uop_t u_mk(coef_t c, logic [3:0] s);
		uop_t u;
		u = '0;
		u.kind = OP_MUL;
		u.asel = SRC_MREG;
		u.bsel = SRC_WORD;
		u.coef = c;
		u.slot = s;
		u.dest = DST_ACC;
		return u;
	endfunction

	// Triangle area, degenerate check, point areas, weights, elevation, then the three slopes.
	localparam uop_t PROG [0:PROG_LEN-1] = '{
		u_area(DST_AREA_SET, AI_D, CI_BX, CI_AX, CI_CY, CI_AY),
		u_area(DST_AREA_SUB, AI_D, CI_BY, CI_AY, CI_CX, CI_AX),
		u_ctl(OP_CHECK, AI_D),
		u_area(DST_AREA_SET, AI_P, CI_BX, CI_PX, CI_CY, CI_PY),
		u_area(DST_AREA_SUB, AI_P, CI_BY, CI_PY, CI_CX, CI_PX),
		u_area(DST_AREA_SET, AI_Q, CI_PX, CI_AX, CI_CY, CI_AY),
		u_area(DST_AREA_SUB, AI_Q, CI_PY, CI_AY, CI_CX, CI_AX),
		u_area(DST_AREA_SET, AI_R, CI_BX, CI_AX, CI_PY, CI_AY),
		u_area(DST_AREA_SUB, AI_R, CI_BY, CI_AY, CI_PX, CI_AX),
		u_ctl(OP_DIV, 2'd0), u_ctl(OP_DIV, 2'd1), u_ctl(OP_DIV, 2'd2),
		u_ww(W_Q, W_Q), u_mw(W_Q), u_mk(COEF_1, 4'd7),
		u_ww(W_Q, W_Q), u_mw(W_R), u_mk(COEF_3, 4'd14),
		u_ww(W_P, W_Q), u_mw(W_Q), u_mk(COEF_3, 4'd11),
		u_ww(W_Q, W_R), u_mw(W_R), u_mk(COEF_3, 4'd15),
		u_ww(W_P, W_Q), u_mw(W_R), u_mk(COEF_6, 4'd12),
		u_ww(W_P, W_P), u_mw(W_Q), u_mk(COEF_3, 4'd9),
		u_ww(W_P, W_P), u_mw(W_P), u_mk(COEF_1, 4'd6),
		u_ww(W_P, W_P), u_mw(W_R), u_mk(COEF_3, 4'd10),
		u_ww(W_P, W_R), u_mw(W_R), u_mk(COEF_3, 4'd13),
		u_ww(W_R, W_R), u_mw(W_R), u_mk(COEF_1, 4'd8),
		u_ctl(OP_ROUND, OI_ELEV),
		u_ww(W_Q, W_Q), u_mk(COEF_3, 4'd11),
		u_ww(W_Q, W_R), u_mk(COEF_6, 4'd12),
		u_ww(W_P, W_Q), u_mk(COEF_6, 4'd9),
		u_ww(W_P, W_P), u_mk(COEF_3, 4'd6),
		u_ww(W_P, W_R), u_mk(COEF_6, 4'd10),
		u_ww(W_R, W_R), u_mk(COEF_3, 4'd13),
		u_ctl(OP_ROUND, OI_SP),
		u_ww(W_Q, W_Q), u_mk(COEF_3, 4'd7),
		u_ww(W_Q, W_R), u_mk(COEF_6, 4'd14),
		u_ww(W_P, W_Q), u_mk(COEF_6, 4'd11),
		u_ww(W_R, W_R), u_mk(COEF_3, 4'd15),
		u_ww(W_P, W_R), u_mk(COEF_6, 4'd12),
		u_ww(W_P, W_P), u_mk(COEF_3, 4'd9),
		u_ctl(OP_ROUND, OI_SQ),
		u_ww(W_Q, W_Q), u_mk(COEF_3, 4'd14),
		u_ww(W_Q, W_R), u_mk(COEF_6, 4'd15),
		u_ww(W_P, W_Q), u_mk(COEF_6, 4'd12),
		u_ww(W_P, W_P), u_mk(COEF_3, 4'd10),
		u_ww(W_P, W_R), u_mk(COEF_6, 4'd13),
		u_ww(W_R, W_R), u_mk(COEF_3, 4'd8),
		u_ctl(OP_ROUND, OI_SR),
		u_ctl(OP_DONE, 2'd0)
	};

endpackage

[design/bezier_triangle_evaluator.sv]
// Cubic Bezier triangle patch evaluator: patch table, microprogram sequencer,
// shared 32x32 partial-product multiplier and a bit-serial divider.
// Depends on bte_pkg.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  request   | start, busy           | mode, word_index, word_value, point_x/y
//  result    | done (one cycle)      | elevation, slope_p/q/r, inside_res,
//            |                       | degenerate
//
// A table write is taken while idle, leaves busy low and gives no result. An
// evaluation runs 74 products on the one multiplier (four 32x32 partial products
// each), three quotient loops on the divider and six control steps; a saturating
// weight skips its loop. A zero-area triangle ends at the degenerate check, after
// the two products of its area.
// busy stays high from acceptance until the cycle with done. Reset clears
// the patch table and the sequencer. The receiver cannot stall the results.
module bezier_triangle_evaluator
	import bte_pkg::*;
#(
	parameter int COORD_BITS    = 24,
	parameter int ORDINATE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       mode,
	input  logic [3:0]                 word_index,
	input  logic signed [WORD_BITS-1:0] word_value,
	input  logic signed [PT_BITS-1:0]  point_x,
	input  logic signed [PT_BITS-1:0]  point_y,
	output logic                       done,
	output logic signed [OUT_BITS-1:0] elevation,
	output logic signed [OUT_BITS-1:0] slope_p,
	output logic signed [OUT_BITS-1:0] slope_q,
	output logic signed [OUT_BITS-1:0] slope_r,
	output logic                       inside_res,
	output logic                       degenerate
);

	localparam int XW  = (COORD_BITS > PT_BITS) ? COORD_BITS : PT_BITS;
	localparam int OBE = (ORDINATE_BITS < WORD_BITS) ? ORDINATE_BITS : WORD_BITS;
	localparam logic signed [63:0] C_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] O_HI = (64'sd1 <<< (OBE - 1)) - 64'sd1;
	localparam int DW  = 100;

	// Saturate a written word to a signed range given by its upper bound.
	function automatic logic signed [63:0] sat_word(logic signed [WORD_BITS-1:0] v,
			logic signed [63:0] hi);
		logic signed [63:0] lo;
		logic signed [63:0] x;
		lo = -hi - 64'sd1;
		x = 64'(v);
		if (x > hi) begin
			return hi;
		end else if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	// Multiplier operand selection.
	function automatic logic signed [63:0] opnd(src_t s, logic [2:0] i, logic [2:0] j,
			logic [7:0][XW-1:0] cs, logic [2:0][WORD_BITS-1:0] ws,
			logic signed [63:0] m, logic signed [63:0] kw);
		logic signed [XW:0] df;
		df = (XW+1)'(signed'(cs[i])) - (XW+1)'(signed'(cs[j]));
		unique case (s)
			SRC_DIFF: return 64'(df);
			SRC_WGT:  return 64'(signed'(ws[i[1:0]]));
			SRC_MREG: return m;
			SRC_WORD: return kw;
			default:  return '0;
		endcase
	endfunction

	// Control state.
	state_t state_q, state_d;
	logic [PC_BITS-1:0] pc_q;
	uop_t uop;

	// Patch table.
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [WORD_BITS-1:0]  ord_q [ORD_SLOTS];

	// Evaluation datapath.
	logic signed [PT_BITS-1:0]   px_q, py_q;
	logic signed [AREA_BITS-1:0] d_q, sp_q, sq_q, sr_q;
	logic signed [WORD_BITS-1:0] wp_q, wq_q, wr_q;
	logic signed [63:0]          m_q, acc_q, r_q;
	logic signed [AREA_BITS-1:0] rw_q;
	logic [63:0]                 ma_q, mb_q;
	logic                        neg_q;
	logic [2:0]                  cnt_q;
	logic [63:0]                 pp_s1;
	logic [1:0]                  ppsh_s1;
	logic [127:0]                prod_q;
	logic [AREA_BITS-1:0]        nmag_q, dmag_q;
	logic                        sn_q, sd_q;
	logic [DW-1:0]               rem_q, dsh_q;
	logic [WORD_BITS-1:0]        quo_q;
	logic [4:0]                  dcnt_q;
	logic signed [OUT_BITS-1:0]  elev_q, slp_q, slq_q, slr_q;
	logic                        inside_q, degen_q;

	logic [7:0][XW-1:0]           cset;
	logic [2:0][WORD_BITS-1:0]    wset;
	logic [3:0]                   oidx;
	logic signed [WORD_BITS-1:0]  ord_rd;
	logic signed [WORD_BITS+2:0]  kword;
	logic signed [63:0]           a_val, b_val;
	logic                         d_zero;
	logic [127:0]                 shifted;
	logic [63:0]                  lim, sat_lo;
	logic [127:0]                 pp_ext;
	logic [DW-1:0]                rem_init, dmax;
	logic signed [63:0]           rounded;
	logic signed [AREA_BITS-1:0]  num_sel;

	assign uop    = PROG[pc_q];
	assign d_zero = (d_q == '0);

	// Operand sources for the shared multiplier.
	always_comb begin
		cset = {XW'(py_q), XW'(px_q), XW'(cy_q), XW'(cx_q),
			XW'(by_q), XW'(bx_q), XW'(ay_q), XW'(ax_q)};
		wset = {wr_q, wq_q, wp_q};
		oidx = uop.slot - SLOT_HA;
		ord_rd = ord_q[oidx];
		unique case (uop.coef)
			COEF_1:  kword = (WORD_BITS+3)'(ord_rd);
			COEF_3:  kword = (WORD_BITS+3)'(ord_rd) + ((WORD_BITS+3)'(ord_rd) <<< 1);
			COEF_6:  kword = ((WORD_BITS+3)'(ord_rd) <<< 1) + ((WORD_BITS+3)'(ord_rd) <<< 2);
			default: kword = '0;
		endcase
		a_val = opnd(uop.asel, uop.ai, uop.aj, cset, wset, m_q, 64'(kword));
		b_val = opnd(uop.bsel, uop.bi, uop.bj, cset, wset, m_q, 64'(kword));
	end

	// Product scaling and saturation to 64 bits.
	always_comb begin
		shifted = uop.sh28 ? (prod_q >> 28) : prod_q;
		lim = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		sat_lo = ((|shifted[127:64]) || (shifted[63:0] > lim)) ? lim : shifted[63:0];
		unique case (ppsh_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = '0;
		endcase
	end

	// Divider set-up and output rounding.
	always_comb begin
		unique case (uop.idx)
			2'd0:    num_sel = sp_q;
			2'd1:    num_sel = sq_q;
			default: num_sel = sr_q;
		endcase
		rem_init = DW'({nmag_q, 28'd0});
		dmax = DW'(dmag_q) << 31;
		rounded = sadd(acc_q, 64'sd1 <<< 27) >>> 28;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && mode) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (uop.kind)
					OP_MUL:   state_d = S_LOAD;
					OP_CHECK: state_d = d_zero ? S_REPLY : S_DISP;
					OP_DIV:   state_d = S_DIV0;
					OP_ROUND: state_d = S_DISP;
					OP_DONE:  state_d = S_REPLY;
					default:  state_d = S_IDLE;
				endcase
			end
			S_LOAD:  state_d = S_MUL;
			S_MUL:   state_d = (cnt_q == 3'd4) ? S_FIN1 : S_MUL;
			S_FIN1:  state_d = S_FIN2;
			S_FIN2:  state_d = S_DISP;
			S_DIV0:  state_d = S_DIV1;
			S_DIV1:  state_d = (rem_init >= dmax) ? S_DIVF : S_DIVS;
			S_DIVS:  state_d = (dcnt_q == 5'd0) ? S_DIVF : S_DIVS;
			S_DIVF:  state_d = S_DISP;
			S_REPLY: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		busy = (state_q != S_IDLE);
		done = (state_q == S_REPLY);
	end

	// Sequencer and patch table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			for (int i = 0; i < ORD_SLOTS; i++) begin
				ord_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				pc_q <= '0;
			end else if ((state_q == S_DISP && (uop.kind == OP_CHECK || uop.kind == OP_ROUND))
					|| state_q == S_FIN2 || state_q == S_DIVF) begin
				pc_q <= pc_q + 1'b1;
			end
			// A write request replaces one table word.
			if (state_q == S_IDLE && start && !mode) begin
				unique case (word_index)
					SLOT_AX: ax_q <= COORD_BITS'(sat_word(word_value, C_HI));
					SLOT_AY: ay_q <= COORD_BITS'(sat_word(word_value, C_HI));
					SLOT_BX: bx_q <= COORD_BITS'(sat_word(word_value, C_HI));
					SLOT_BY: by_q <= COORD_BITS'(sat_word(word_value, C_HI));
					SLOT_CX: cx_q <= COORD_BITS'(sat_word(word_value, C_HI));
					SLOT_CY: cy_q <= COORD_BITS'(sat_word(word_value, C_HI));
					default: ord_q[word_index - SLOT_HA] <= WORD_BITS'(sat_word(word_value, O_HI));
				endcase
			end
		end
	end

	// Arithmetic datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				px_q <= point_x;
				py_q <= point_y;
				acc_q <= '0;
			end
			S_DISP: begin
				if (uop.kind == OP_CHECK && d_zero) begin
					elev_q <= '0;
					slp_q <= '0;
					slq_q <= '0;
					slr_q <= '0;
					inside_q <= 1'b0;
					degen_q <= 1'b1;
				end
				if (uop.kind == OP_ROUND) begin
					unique case (uop.idx)
						OI_ELEV: elev_q <= OUT_BITS'(rounded);
						OI_SP:   slp_q <= OUT_BITS'(rounded);
						OI_SQ:   slq_q <= OUT_BITS'(rounded);
						OI_SR:   slr_q <= OUT_BITS'(rounded);
						default: elev_q <= OUT_BITS'(rounded);
					endcase
					acc_q <= '0;
				end
				if (uop.kind == OP_DONE) begin
					inside_q <= !(sp_q[AREA_BITS-1] || sq_q[AREA_BITS-1] || sr_q[AREA_BITS-1]);
					degen_q <= 1'b0;
				end
			end
			// Operand magnitudes and product sign.
			S_LOAD: begin
				ma_q <= a_val[63] ? 64'(-a_val) : 64'(a_val);
				mb_q <= b_val[63] ? 64'(-b_val) : 64'(b_val);
				neg_q <= a_val[63] ^ b_val[63];
				prod_q <= '0;
				cnt_q <= '0;
			end
			// Four 32x32 partial products, each registered in pp_s1 and added in the cycle after.
			S_MUL: begin
				if (cnt_q != 3'd4) begin
					pp_s1 <= (cnt_q[1] ? ma_q[63:32] : ma_q[31:0])
						* (cnt_q[0] ? mb_q[63:32] : mb_q[31:0]);
					ppsh_s1 <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
				end
				if (cnt_q != 3'd0) begin
					prod_q <= prod_q + pp_ext;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			S_FIN1: begin
				r_q <= neg_q ? -signed'(sat_lo) : signed'(sat_lo);
				rw_q <= neg_q ? -signed'(prod_q[AREA_BITS-1:0]) : signed'(prod_q[AREA_BITS-1:0]);
			end
			S_FIN2: begin
				unique case (uop.dest)
					DST_AREA_SET: begin
						unique case (uop.idx)
							AI_D:    d_q <= rw_q;
							AI_P:    sp_q <= rw_q;
							AI_Q:    sq_q <= rw_q;
							default: sr_q <= rw_q;
						endcase
					end
					DST_AREA_SUB: begin
						unique case (uop.idx)
							AI_D:    d_q <= d_q - rw_q;
							AI_P:    sp_q <= sp_q - rw_q;
							AI_Q:    sq_q <= sq_q - rw_q;
							default: sr_q <= sr_q - rw_q;
						endcase
					end
					DST_MREG: m_q <= r_q;
					DST_ACC:  acc_q <= sadd(acc_q, r_q);
					default:  m_q <= r_q;
				endcase
			end
			// Quotient magnitudes and signs.
			S_DIV0: begin
				sn_q <= num_sel[AREA_BITS-1];
				sd_q <= d_q[AREA_BITS-1];
				nmag_q <= num_sel[AREA_BITS-1] ? AREA_BITS'(-num_sel) : AREA_BITS'(num_sel);
				dmag_q <= d_q[AREA_BITS-1] ? AREA_BITS'(-d_q) : AREA_BITS'(d_q);
			end
			S_DIV1: begin
				rem_q <= rem_init;
				dsh_q <= DW'(dmag_q) << 30;
				dcnt_q <= 5'd30;
				quo_q <= (rem_init >= dmax) ? {1'b1, 31'd0} : '0;
			end
			// Restoring division, one quotient bit a cycle.
			S_DIVS: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[WORD_BITS-2:0], rem_q >= dsh_q};
				dsh_q <= dsh_q >> 1;
				dcnt_q <= dcnt_q - 1'b1;
			end
			S_DIVF: begin
				unique case (uop.idx)
					2'd0: begin
						wp_q <= (sn_q != sd_q) ? -signed'(quo_q)
							: (quo_q[WORD_BITS-1] ? {1'b0, {31{1'b1}}} : signed'(quo_q));
					end
					2'd1: begin
						wq_q <= (sn_q != sd_q) ? -signed'(quo_q)
							: (quo_q[WORD_BITS-1] ? {1'b0, {31{1'b1}}} : signed'(quo_q));
					end
					default: begin
						wr_q <= (sn_q != sd_q) ? -signed'(quo_q)
							: (quo_q[WORD_BITS-1] ? {1'b0, {31{1'b1}}} : signed'(quo_q));
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign elevation  = elev_q;
	assign slope_p    = slp_q;
	assign slope_q    = slq_q;
	assign slope_r    = slr_q;
	assign inside_res = inside_q;
	assign degenerate = degen_q;

endmodule

[design/bte_checker.sv]
// Port-level checker for the Bezier triangle evaluator and its bind.
// Depends on bte_pkg and on the top level's port list.
module bte_checker
	import bte_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       mode,
	input logic                       done,
	input logic signed [OUT_BITS-1:0] elevation,
	input logic signed [OUT_BITS-1:0] slope_p,
	input logic signed [OUT_BITS-1:0] slope_q,
	input logic signed [OUT_BITS-1:0] slope_r,
	input logic                       inside_res,
	input logic                       degenerate
);

	// A result only appears while a request is in progress.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe without a request in progress");

	// The block is free again straight after a result.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("block still busy after its result");

	// A degenerate triangle gives all-zero values.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (elevation == 0 && slope_p == 0 && slope_q == 0
			&& slope_r == 0 && !inside_res))
		else $error("degenerate result with non-zero values");

	// A table write finishes at once and yields no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode) |=> (!busy && !done))
		else $error("table write produced activity");

	// An evaluation request makes the block busy in the next cycle, with no result yet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode) |=> (busy && !done))
		else $error("evaluation request not taken up");

endmodule

bind bezier_triangle_evaluator bte_checker u_bte_checker (.*);

[verif/tb_bezier_triangle_evaluator.sv]
// Self-checking testbench for bezier_triangle_evaluator: directed patches, then random ones.
// Holds its own bit-exact model of the patch table and the evaluation arithmetic.
// Depends on bte_pkg and the bezier_triangle_evaluator RTL.
module tb_bezier_triangle_evaluator
	import bte_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int SETTLE_CYCLES = 800;

	typedef struct {
		logic signed [OUT_BITS-1:0] elev;
		logic signed [OUT_BITS-1:0] sp;
		logic signed [OUT_BITS-1:0] sq;
		logic signed [OUT_BITS-1:0] sr;
		logic in_tri;
		logic degen;
	} surface_t;

	// Cubic terms: weight indexes, multiplier, table slot.
	localparam int CUBIC_TERMS [10][5] = '{
		'{1,1,1,1,7}, '{1,1,2,3,14}, '{0,1,1,3,11}, '{1,2,2,3,15}, '{0,1,2,6,12},
		'{0,0,1,3,9}, '{0,0,0,1,6}, '{0,0,2,3,10}, '{0,2,2,3,13}, '{2,2,2,1,8}
	};
	// Quadratic terms of each partial derivative.
	localparam int SLOPE_TERMS [3][6][4] = '{
		'{'{1,1,3,11}, '{1,2,6,12}, '{0,1,6,9}, '{0,0,3,6}, '{0,2,6,10}, '{2,2,3,13}},
		'{'{1,1,3,7}, '{1,2,6,14}, '{0,1,6,11}, '{2,2,3,15}, '{0,2,6,12}, '{0,0,3,9}},
		'{'{1,1,3,14}, '{1,2,6,15}, '{0,1,6,12}, '{0,0,3,10}, '{0,2,6,13}, '{2,2,3,8}}
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic mode;
	logic [3:0] word_index;
	logic signed [WORD_BITS-1:0] word_value;
	logic signed [PT_BITS-1:0] point_x;
	logic signed [PT_BITS-1:0] point_y;
	logic done;
	logic signed [OUT_BITS-1:0] elevation;
	logic signed [OUT_BITS-1:0] slope_p;
	logic signed [OUT_BITS-1:0] slope_q;
	logic signed [OUT_BITS-1:0] slope_r;
	logic inside_res;
	logic degenerate;

	logic signed [31:0] patch_model [16];
	surface_t pending_surfaces [$];
	int errors = 0;
	int cycles = 0;
	bit no_gaps = 0;

	bezier_triangle_evaluator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.word_index(word_index), .word_value(word_value), .point_x(point_x),
		.point_y(point_y), .done(done), .elevation(elevation), .slope_p(slope_p),
		.slope_q(slope_q), .slope_r(slope_r), .inside_res(inside_res),
		.degenerate(degenerate)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Doubled signed area, exact.
	function automatic logic signed [127:0] twice_area(logic signed [127:0] ux, uy, vx, vy,
			wx, wy);
		return (vx - ux) * (wy - uy) - (vy - uy) * (wx - ux);
	endfunction

	// Q4.28 barycentric weight, magnitude truncated, saturated.
	function automatic logic signed [63:0] bary_weight(logic signed [127:0] num, den);
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		if ((n << 28) >= (d << 31))
			q = 128'd1 << 31;
		else
			q = (n << 28) / d;
		if ((num < 0) != (den < 0))
			return -$signed(q[63:0]);
		return q > 128'h7FFF_FFFF ? 64'sh7FFF_FFFF : $signed(q[63:0]);
	endfunction

	// Product shifted right with truncated magnitude, saturated to 64 bits.
	function automatic logic signed [63:0] mul_sat(logic signed [63:0] a, b, int sh);
		logic signed [127:0] ae;
		logic signed [127:0] be;
		logic [127:0] p;
		logic [127:0] lim;
		logic neg;
		ae = a;
		be = b;
		neg = (a < 0) != (b < 0);
		p = ((ae < 0 ? -ae : ae) * (be < 0 ? -be : be)) >> sh;
		lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
		if (p > lim)
			p = lim;
		return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
	endfunction

	function automatic logic signed [63:0] add_sat(logic signed [63:0] a, b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic signed [OUT_BITS-1:0] round_q28(logic signed [63:0] y);
		logic signed [63:0] t;
		t = add_sat(y, 64'sd1 << 27);
		t = t >>> 28;
		return t[OUT_BITS-1:0];
	endfunction

	// Evaluate the modelled patch at one point.
	function automatic surface_t surface_at(logic signed [PT_BITS-1:0] px, py);
		surface_t s;
		logic signed [127:0] d;
		logic signed [127:0] ar [3];
		logic signed [63:0] w [3];
		logic signed [63:0] acc;
		logic signed [63:0] m;
		s = '{default: '0};
		d = twice_area(patch_model[0], patch_model[1], patch_model[2], patch_model[3],
			patch_model[4], patch_model[5]);
		if (d == 0) begin
			s.degen = 1'b1;
			return s;
		end
		ar[0] = twice_area(px, py, patch_model[2], patch_model[3], patch_model[4],
			patch_model[5]);
		ar[1] = twice_area(patch_model[0], patch_model[1], px, py, patch_model[4],
			patch_model[5]);
		ar[2] = twice_area(patch_model[0], patch_model[1], patch_model[2], patch_model[3],
			px, py);
		for (int i = 0; i < 3; i++)
			w[i] = bary_weight(ar[i], d);
		acc = 0;
		for (int i = 0; i < 10; i++) begin
			m = mul_sat(w[CUBIC_TERMS[i][0]], w[CUBIC_TERMS[i][1]], 28);
			m = mul_sat(m, w[CUBIC_TERMS[i][2]], 28);
			acc = add_sat(acc, mul_sat(m, 64'(CUBIC_TERMS[i][3]) *
				64'(patch_model[CUBIC_TERMS[i][4]]), 0));
		end
		s.elev = round_q28(acc);
		for (int k = 0; k < 3; k++) begin
			acc = 0;
			for (int j = 0; j < 6; j++) begin
				m = mul_sat(w[SLOPE_TERMS[k][j][0]], w[SLOPE_TERMS[k][j][1]], 28);
				acc = add_sat(acc, mul_sat(m, 64'(SLOPE_TERMS[k][j][2]) *
					64'(patch_model[SLOPE_TERMS[k][j][3]]), 0));
			end
			case (k)
				0: s.sp = round_q28(acc);
				1: s.sq = round_q28(acc);
				default: s.sr = round_q28(acc);
			endcase
		end
		s.in_tri = (ar[0] >= 0) && (ar[1] >= 0) && (ar[2] >= 0);
		return s;
	endfunction

	// Present one request, hold it until accepted, then update the model.
	task automatic send(bit m, logic [3:0] idx, logic [31:0] val, logic [23:0] x, y);
		int gap;
		logic signed [31:0] v;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		word_index <= idx;
		word_value <= val;
		point_x <= x;
		point_y <= y;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (m) begin
			pending_surfaces = {pending_surfaces, surface_at(x, y)};
		end else begin
			v = val;
			if (idx < SLOT_HA) begin
				if (v > 32'sd8388607)
					v = 32'sd8388607;
				else if (v < -32'sd8388608)
					v = -32'sd8388608;
			end
			patch_model[idx] = v;
		end
	endtask

	task automatic write_word(logic [3:0] idx, logic [31:0] val);
		send(1'b0, idx, val, 24'($urandom), 24'($urandom));
	endtask

	// Evaluation requests carry random noise in the unused fields.
	task automatic evaluate(logic [23:0] x, y);
		send(1'b1, 4'($urandom), $urandom, x, y);
	endtask

	// Stop sending until every expected result has been checked.
	task automatic drain;
		start <= 1'b0;
		while (pending_surfaces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_degenerate;
		evaluate(24'h123456, 24'hABCDEF);
		drain();
	endtask

	// Corners beyond range saturate; extreme ordinates; corner and far points.
	task automatic test_wide_triangle;
		write_word(SLOT_AX, 32'h7FFF_FFFF);
		write_word(SLOT_AY, 32'h8000_0000);
		write_word(SLOT_BX, 32'hFF80_0000);
		write_word(SLOT_BY, 32'hFF80_0000);
		write_word(SLOT_CX, 32'h0000_0000);
		write_word(SLOT_CY, 32'h0080_0000);
		write_word(SLOT_HA, 32'h8000_0000);
		write_word(4'd15, 32'h7FFF_FFFF);
		evaluate(24'h7FFFFF, 24'h800000);
		evaluate(24'h800000, 24'h7FFFFF);
		evaluate(24'h000000, 24'h000000);
		evaluate(24'h7FFFFF, 24'h7FFFFF);
		drain();
	endtask

	// A unit triangle makes weights of distant points saturate.
	task automatic test_weight_saturation;
		write_word(SLOT_AX, 0);
		write_word(SLOT_AY, 0);
		write_word(SLOT_BX, 1);
		write_word(SLOT_BY, 0);
		write_word(SLOT_CX, 0);
		write_word(SLOT_CY, 1);
		evaluate(24'h800000, 24'h7FFFFF);
		evaluate(24'h000000, 24'h000000);
		drain();
	endtask

	// Collinear corners give a zero-area triangle.
	task automatic test_collinear;
		write_word(SLOT_CX, 2);
		write_word(SLOT_CY, 0);
		evaluate(24'h000001, 24'h000001);
		drain();
	endtask

	function automatic logic [31:0] rand_coord(int scale);
		case (scale)
			0: return 32'($signed(11'($urandom)));
			1: return 32'($signed(18'($urandom)));
			2: return 32'($signed(24'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	// Mostly whole patches followed by evaluations, with stray requests mixed in.
	task automatic test_random_patches;
		int sent;
		int scale;
		int evals;
		logic [3:0] slot;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				no_gaps = ~no_gaps;
			if ($urandom_range(0, 9) < 7) begin
				scale = $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0) begin
					// Rewrite a few random slots only.
					repeat ($urandom_range(1, 5)) begin
						slot = 4'($urandom);
						write_word(slot, slot < SLOT_HA ? rand_coord(scale) : $urandom);
						sent++;
					end
				end else begin
					for (int i = 0; i < 16; i++) begin
						if (i < SLOT_HA)
							write_word(4'(i), rand_coord(scale));
						else if ($urandom_range(0, 1))
							write_word(4'(i), $urandom);
						else
							write_word(4'(i), 32'($signed(16'($urandom))));
					end
					sent += 16;
					if ($urandom_range(0, 7) == 0) begin
						write_word(SLOT_CX, patch_model[SLOT_AX]);
						write_word(SLOT_CY, patch_model[SLOT_AY]);
						sent += 2;
					end
				end
				evals = $urandom_range(1, 8);
				repeat (evals) begin
					if ($urandom_range(0, 3) == 0)
						evaluate(24'($urandom), 24'($urandom));
					else
						evaluate(24'(rand_coord(scale)), 24'(rand_coord(scale)));
				end
				sent += evals;
			end else begin
				send(1'($urandom), 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
				sent++;
			end
		end
		no_gaps = 0;
		drain();
	endtask

	task automatic check_field(string name, logic signed [OUT_BITS-1:0] exp_v,
			logic signed [OUT_BITS-1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// Compare each result with the oldest expected surface value.
	always @(posedge clk) begin
		surface_t exp_s;
		if (arst_n && done) begin
			if (pending_surfaces.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding", $time);
			end else begin
				exp_s = pending_surfaces.pop_front();
				check_field("elevation", exp_s.elev, elevation);
				check_field("slope_p", exp_s.sp, slope_p);
				check_field("slope_q", exp_s.sq, slope_q);
				check_field("slope_r", exp_s.sr, slope_r);
				check_field("inside_res", 48'(exp_s.in_tri), 48'(inside_res));
				check_field("degenerate", 48'(exp_s.degen), 48'(degenerate));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_bezier_triangle_evaluator: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = 1'b0;
		word_index = '0;
		word_value = '0;
		point_x = '0;
		point_y = '0;
		for (int i = 0; i < 16; i++)
			patch_model[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_degenerate();
		test_wide_triangle();
		test_weight_saturation();
		test_collinear();
		test_random_patches();
		if (errors == 0 && pending_surfaces.size() == 0)
			$display("tb_bezier_triangle_evaluator: PASS");
		else
			$display("tb_bezier_triangle_evaluator: FAIL");
		$finish;
	end

endmodule

[files.f]
design/bte_pkg.sv
design/bezier_triangle_evaluator.sv
design/bte_checker.sv
verif/tb_bezier_triangle_evaluator.sv
